// ===== hw/rtl/rle_hamming_limit_check_assert.svh =====
// assertion macros for the rle hamming limit check rtl
`ifndef RLE_HAMMING_LIMIT_CHECK_ASSERT_SVH
`define RLE_HAMMING_LIMIT_CHECK_ASSERT_SVH

`ifndef SYNTH
// clocked check, masked while reset is high
`define RLEHD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// clocked check that also holds through reset
`define RLEHD_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define RLEHD_ASSERT(lbl, prop, msg)
`define RLEHD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hw/rtl/rlehd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rlehd_pkg;

   localparam int SYMBOL_W = 8;
   localparam int LENGTH_W = 16;
   localparam int COUNT_W  = 26;

   // saturation value of the mismatch count
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // one stored run: symbol over length
   typedef struct packed {
      logic [SYMBOL_W-1:0] symbol;
      logic [LENGTH_W-1:0] length;
   } rlehd_run_type;

endpackage

`default_nettype wire

// ===== hw/rtl/rlehd_run_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rlehd_run_store #(
   parameter int MAX_RUNS = 1024,
   localparam int AddrW = $clog2(MAX_RUNS),
   localparam int CntW  = $clog2(MAX_RUNS + 1)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire logic                          which_string,
   input  wire logic [rlehd_pkg::SYMBOL_W-1:0] run_symbol,
   input  wire logic [rlehd_pkg::LENGTH_W-1:0] run_length,
   input  wire logic                          last_run,
   input  wire logic [AddrW-1:0]              rd_addr_first,
   input  wire logic [AddrW-1:0]              rd_addr_second,
   output rlehd_pkg::rlehd_run_type           rd_first,
   output rlehd_pkg::rlehd_run_type           rd_second,
   output logic                               launch,
   output logic [CntW-1:0]                    first_total,
   output logic [CntW-1:0]                    second_total
);
   import rlehd_pkg::*;

   rlehd_run_type first_mem [MAX_RUNS];
   rlehd_run_type second_mem [MAX_RUNS];
   rlehd_run_type rd_first_ff, rd_second_ff;
   rlehd_run_type entry;

   logic [CntW-1:0] first_total_ff, first_total_in;
   logic [CntW-1:0] second_total_ff, second_total_in;
   logic            first_done_ff, first_done_in;
   logic            second_done_ff, second_done_in;
   logic            take_first, take_second;
   logic            wr_first, wr_second;
   logic [CntW-1:0] first_count, second_count;
   logic            first_done, second_done;

   // item intake: runs for a finished string are dropped, full lists stop storing
   always_comb begin
      entry.symbol = run_symbol;
      entry.length = run_length;
      take_first   = accept && !which_string && !first_done_ff;
      take_second  = accept && which_string && !second_done_ff;
      wr_first     = take_first && (first_total_ff != CntW'(MAX_RUNS));
      wr_second    = take_second && (second_total_ff != CntW'(MAX_RUNS));
      first_count  = wr_first ? first_total_ff + 1'b1 : first_total_ff;
      second_count = wr_second ? second_total_ff + 1'b1 : second_total_ff;
      first_done   = first_done_ff || (take_first && last_run);
      second_done  = second_done_ff || (take_second && last_run);
      launch       = (take_first || take_second) && first_done && second_done;
      if (launch) begin
         first_total_in  = '0;
         second_total_in = '0;
         first_done_in   = 1'b0;
         second_done_in  = 1'b0;
      end else begin
         first_total_in  = first_count;
         second_total_in = second_count;
         first_done_in   = first_done;
         second_done_in  = second_done;
      end
   end

   assign first_total  = first_count;
   assign second_total = second_count;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         first_total_ff  <= '0;
         second_total_ff <= '0;
         first_done_ff   <= 1'b0;
         second_done_ff  <= 1'b0;
      end else begin
         first_total_ff  <= first_total_in;
         second_total_ff <= second_total_in;
         first_done_ff   <= first_done_in;
         second_done_ff  <= second_done_in;
      end
   end

   // run memories, one write and one registered read each
   always_ff @(posedge clock) begin
      if (wr_first) begin
         first_mem[first_total_ff[AddrW-1:0]] <= entry;
      end
      rd_first_ff <= first_mem[rd_addr_first];
   end

   always_ff @(posedge clock) begin
      if (wr_second) begin
         second_mem[second_total_ff[AddrW-1:0]] <= entry;
      end
      rd_second_ff <= second_mem[rd_addr_second];
   end

   assign rd_first  = rd_first_ff;
   assign rd_second = rd_second_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/rlehd_merge_walk.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rlehd_merge_walk #(
   parameter int MAX_RUNS = 1024,
   localparam int AddrW = $clog2(MAX_RUNS),
   localparam int CntW  = $clog2(MAX_RUNS + 1)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          launch,
   input  wire logic [CntW-1:0]               first_total,
   input  wire logic [CntW-1:0]               second_total,
   input  wire rlehd_pkg::rlehd_run_type      rd_first,
   input  wire rlehd_pkg::rlehd_run_type      rd_second,
   input  wire logic [rlehd_pkg::COUNT_W-1:0] mismatch_limit,
   output logic [AddrW-1:0]                   rd_addr_first,
   output logic [AddrW-1:0]                   rd_addr_second,
   output logic                               busy,
   output logic                               rsp_valid,
   output logic [rlehd_pkg::COUNT_W-1:0]      rsp_mismatches_seen,
   output logic                               rsp_within_limit
);
   import rlehd_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_PRIME = 2'd1;
   localparam logic [1:0] ST_WALK  = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [CntW-1:0]     idx1_ff, idx1_in, idx2_ff, idx2_in;
   logic [CntW-1:0]     total1_ff, total1_in, total2_ff, total2_in;
   logic [LENGTH_W-1:0] rem1_ff, rem1_in, rem2_ff, rem2_in;
   logic                load1_ff, load1_in, load2_ff, load2_in;
   logic [COUNT_W-1:0]  delta_ff, delta_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic                rsp_within_ff, rsp_within_in;

   logic [LENGTH_W-1:0] rem1, rem2, overlap;
   logic [LENGTH_W:0]   diff, neg;
   logic [COUNT_W:0]    sum;
   logic [COUNT_W-1:0]  delta_next;
   logic                in_range;

   // shared step unit: one subtract decides order and overlap; it or its negation is the leftover
   always_comb begin
      rem1       = load1_ff ? rd_first.length : rem1_ff;
      rem2       = load2_ff ? rd_second.length : rem2_ff;
      diff       = {1'b0, rem1} - {1'b0, rem2};
      neg        = '0 - diff;
      overlap    = diff[LENGTH_W] ? rem1 : rem2;
      sum        = {1'b0, delta_ff} + (COUNT_W + 1)'(overlap);
      if (rd_first.symbol != rd_second.symbol) begin
         delta_next = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
      end else begin
         delta_next = delta_ff;
      end
      in_range   = (idx1_ff < total1_ff) && (idx2_ff < total2_ff);
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      idx1_in       = idx1_ff;
      idx2_in       = idx2_ff;
      total1_in     = total1_ff;
      total2_in     = total2_ff;
      rem1_in       = rem1_ff;
      rem2_in       = rem2_ff;
      load1_in      = 1'b0;
      load2_in      = 1'b0;
      delta_in      = delta_ff;
      rsp_valid_in  = 1'b0;
      rsp_count_in  = rsp_count_ff;
      rsp_within_in = rsp_within_ff;
      case (state_ff)
         ST_IDLE: begin
            if (launch) begin
               state_in  = ST_PRIME;
               idx1_in   = '0;
               idx2_in   = '0;
               total1_in = first_total;
               total2_in = second_total;
               delta_in  = '0;
            end
         end
         ST_PRIME: begin
            // first entries of both lists come out of the memories now
            state_in = ST_WALK;
            load1_in = 1'b1;
            load2_in = 1'b1;
         end
         ST_WALK: begin
            if (!in_range) begin
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_count_in  = delta_ff;
               rsp_within_in = (delta_ff <= mismatch_limit);
            end else begin
               delta_in = delta_next;
               if (diff[LENGTH_W]) begin
                  // second run is longer: first list moves on
                  rem2_in  = neg[LENGTH_W-1:0];
                  idx1_in  = idx1_ff + 1'b1;
                  load1_in = 1'b1;
               end else if (diff != '0) begin
                  // first run is longer: second list moves on
                  rem1_in  = diff[LENGTH_W-1:0];
                  idx2_in  = idx2_ff + 1'b1;
                  load2_in = 1'b1;
               end else begin
                  idx1_in  = idx1_ff + 1'b1;
                  idx2_in  = idx2_ff + 1'b1;
                  load1_in = 1'b1;
                  load2_in = 1'b1;
               end
               if (delta_next >= mismatch_limit) begin
                  state_in      = ST_IDLE;
                  rsp_valid_in  = 1'b1;
                  rsp_count_in  = delta_next;
                  rsp_within_in = (delta_next <= mismatch_limit);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // read addresses follow the next indexes so data lines up with the step
   assign rd_addr_first  = idx1_in[AddrW-1:0];
   assign rd_addr_second = idx2_in[AddrW-1:0];

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         load1_ff     <= 1'b0;
         load2_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         load1_ff     <= load1_in;
         load2_ff     <= load2_in;
      end
   end

   // walk datapath
   always_ff @(posedge clock) begin
      idx1_ff       <= idx1_in;
      idx2_ff       <= idx2_in;
      total1_ff     <= total1_in;
      total2_ff     <= total2_in;
      rem1_ff       <= rem1_in;
      rem2_ff       <= rem2_in;
      delta_ff      <= delta_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_within_ff <= rsp_within_in;
   end

   assign busy                = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_mismatches_seen = rsp_count_ff;
   assign rsp_within_limit    = rsp_within_ff;

`include "rle_hamming_limit_check_assert.svh"

   `RLEHD_ASSERT_ALWAYS(a_rsp_single, rsp_valid |=> !rsp_valid, "result strobe held two cycles")
   `RLEHD_ASSERT(a_launch_idle, launch |-> (state_ff == ST_IDLE), "walk launched while busy")
   `RLEHD_ASSERT(a_idx_bound,
      (state_ff == ST_WALK) |-> (idx1_ff <= total1_ff && idx2_ff <= total2_ff),
      "walk index past list end")
   `RLEHD_ASSERT(a_count_grows,
      (state_ff == ST_WALK && $past(state_ff) == ST_WALK) |-> (delta_ff >= $past(delta_ff)),
      "mismatch count went down")

endmodule

`default_nettype wire

// ===== hw/rtl/rle_hamming_limit_check.sv =====
// channel   ports                                  handshake
// -------   -----------------------------------    ---------------------------
// request   req_which_string/symbol/length/last    start high, busy low
// result    rsp_mismatches_seen, rsp_within_limit  rsp_valid, one cycle only
// config    csr_wr_data                            csr_wr_en, no wait
//
// a run that does not complete the pair is at most one memory write. the run
// that completes both strings starts the walk: a prime state reads the first
// entries, then the walk state does merge steps through the shared
// subtractor until a list ends or the count reaches the limit; busy is high
// throughout. rsp_valid rises in the same cycle that busy falls; the receiver
// cannot stall it. reset is synchronous; the run memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module rle_hamming_limit_check #(
   parameter int MAX_RUNS = 1024
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_which_string,
   input  wire logic [rlehd_pkg::SYMBOL_W-1:0] req_run_symbol,
   input  wire logic [rlehd_pkg::LENGTH_W-1:0] req_run_length,
   input  wire logic                          req_last_run,
   output logic                               rsp_valid,
   output logic [rlehd_pkg::COUNT_W-1:0]      rsp_mismatches_seen,
   output logic                               rsp_within_limit,
   input  wire logic                          csr_wr_en,
   input  wire logic [rlehd_pkg::COUNT_W-1:0] csr_wr_data
);
   import rlehd_pkg::*;

   localparam int AddrW = $clog2(MAX_RUNS);
   localparam int CntW  = $clog2(MAX_RUNS + 1);

   logic [COUNT_W-1:0] limit_ff;
   logic               accept;
   logic               launch;
   logic [CntW-1:0]    first_total, second_total;
   logic [AddrW-1:0]   rd_addr_first, rd_addr_second;
   rlehd_run_type      rd_first, rd_second;

   // mismatch limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   assign accept = start && !busy;

   rlehd_run_store #(
      .MAX_RUNS (MAX_RUNS)
   ) u_store (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .which_string   (req_which_string),
      .run_symbol     (req_run_symbol),
      .run_length     (req_run_length),
      .last_run       (req_last_run),
      .rd_addr_first  (rd_addr_first),
      .rd_addr_second (rd_addr_second),
      .rd_first       (rd_first),
      .rd_second      (rd_second),
      .launch         (launch),
      .first_total    (first_total),
      .second_total   (second_total)
   );

   rlehd_merge_walk #(
      .MAX_RUNS (MAX_RUNS)
   ) u_walk (
      .clock               (clock),
      .reset               (reset),
      .launch              (launch),
      .first_total         (first_total),
      .second_total        (second_total),
      .rd_first            (rd_first),
      .rd_second           (rd_second),
      .mismatch_limit      (limit_ff),
      .rd_addr_first       (rd_addr_first),
      .rd_addr_second      (rd_addr_second),
      .busy                (busy),
      .rsp_valid           (rsp_valid),
      .rsp_mismatches_seen (rsp_mismatches_seen),
      .rsp_within_limit    (rsp_within_limit)
   );

endmodule

`default_nettype wire
